/* rtl/nmb_pkg.sv */
`default_nettype none

package nmb_pkg;

    // Sizes of the accumulator store.
    localparam int MAX_RANK = 4;
    localparam int POLY_LEN = 256;
    localparam int PAIRS    = POLY_LEN / 2;
    localparam int DEPTH    = MAX_RANK * PAIRS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int RANK_W   = $clog2(MAX_RANK + 1);

    // Field widths.
    localparam int ROW_W   = 2;
    localparam int COL_W   = 2;
    localparam int PAIR_W  = 7;
    localparam int COEF_W  = 12;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int RANKR_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Remainder pipeline: the dividend is padded to SUM_W bits and consumed
    // STEP_BITS bits per stage.
    localparam int STEP_BITS = 4;
    localparam int SUM_W     = 28;
    localparam int RED_STEPS = SUM_W / STEP_BITS;

    // Accumulator entry: even sum in the low field, odd sum in the high field.
    localparam int FIELD_W   = 14;
    localparam int ENTRY_W   = 2 * FIELD_W;
    localparam int ACC_PAD_W = 16;
    localparam int ACC_STEPS = ACC_PAD_W / STEP_BITS;

    // Stage positions along the pipeline.
    localparam int ST_MUL  = 1;
    localparam int ST_X    = ST_MUL + RED_STEPS + 1;
    localparam int ST_ACC  = ST_X + RED_STEPS;
    localparam int ST_OUT  = ST_ACC + 1;
    localparam int ST_RD   = ST_ACC - ACC_STEPS - 1;
    localparam int N_ST    = ST_OUT + 1;
    localparam int FWD_DEPTH = ST_ACC - ST_RD;

    // Reset values and limits of the configuration.
    localparam logic [COEF_W-1:0]  MOD_RESET  = 12'd3329;
    localparam logic [COEF_W-1:0]  MOD_MIN    = 12'd2;
    localparam logic [RANKR_W-1:0] RANK_RESET = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 2'd1;

    // Per-item control that travels with the data.
    typedef struct packed {
        logic              first;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [PAIR_W-1:0] pair;
        logic [ADDR_W-1:0] addr;
    } t_meta;

    // A finished sum kept for forwarding to younger items.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [COEF_W-1:0] e0;
        logic [COEF_W-1:0] e1;
    } t_fwd;

    // One finished result pair.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [PAIR_W-1:0] pair;
        logic [COEF_W-1:0] t0;
        logic [COEF_W-1:0] t1;
    } t_res;

    // Restoring remainder over STEP_BITS dividend bits. The partial remainder
    // must be below q on entry; it stays below q on exit.
    function automatic logic [COEF_W-1:0] rem_chunk(
        input logic [COEF_W-1:0]    r,
        input logic [STEP_BITS-1:0] chunk,
        input logic [COEF_W-1:0]    q
    );
        logic [COEF_W:0]   t;
        logic [COEF_W-1:0] acc;
        acc = r;
        for (int b = STEP_BITS - 1; b >= 0; b--) begin
            t = {acc, chunk[b]};
            if (t >= {1'b0, q}) begin
                t = t - {1'b0, q};
            end
            acc = t[COEF_W-1:0];
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* rtl/ntt_domain_matvec_basemul.sv */
`default_nettype none

// NTT-domain matrix-vector base multiplier. Each request carries one
// coefficient pair of A[row,col] and s[col] with its gamma; the block forms
// the base-case product, reduces it mod q and accumulates it per (row, pair)
// in a 512-entry store, emitting the reduced pair when col is rank-1. One
// request is taken every cycle unless the input stalls; a request's result
// is registered into the two-entry output buffer at the end of the pipeline.
// The whole pipeline advances together and holds only while that buffer is
// full, so the input stalls only when two results are waiting. Requests with
// row or col not below the rank are taken and dropped. Columns of a row and
// pair must come in order 0..rank-1, and the first column of an entry must
// be 0 before other columns read it. The configuration port is always ready;
// write it only while no request is in flight.
module ntt_domain_matvec_basemul (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [nmb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [nmb_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [nmb_pkg::ROW_W-1:0]           i_row,
    input  wire logic [nmb_pkg::COL_W-1:0]           i_col,
    input  wire logic [nmb_pkg::PAIR_W-1:0]          i_pair_index,
    input  wire logic [nmb_pkg::COEF_W-1:0]          i_a_even,
    input  wire logic [nmb_pkg::COEF_W-1:0]          i_a_odd,
    input  wire logic [nmb_pkg::COEF_W-1:0]          i_s_even,
    input  wire logic [nmb_pkg::COEF_W-1:0]          i_s_odd,
    input  wire logic [nmb_pkg::COEF_W-1:0]          i_twiddle,

    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [nmb_pkg::ROW_W-1:0]                o_out_row,
    output logic [nmb_pkg::PAIR_W-1:0]               o_out_pair,
    output logic [nmb_pkg::COEF_W-1:0]               o_t_even,
    output logic [nmb_pkg::COEF_W-1:0]               o_t_odd
);

    // Configuration registers.
    logic [nmb_pkg::COEF_W-1:0]  r_q;
    logic [nmb_pkg::RANKR_W-1:0] r_rank;

    // Pipeline control.
    logic                   en;
    logic                   in_take;
    logic                   in_ok;
    logic [nmb_pkg::RANK_W-1:0] k_eff;
    nmb_pkg::t_meta         n_meta;
    logic                   r_vld  [nmb_pkg::N_ST];
    nmb_pkg::t_meta         r_meta [nmb_pkg::N_ST];

    // Operands and products.
    logic [nmb_pkg::COEF_W-1:0] r_a0, r_a1, r_b0, r_b1, r_g;
    logic [nmb_pkg::PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [nmb_pkg::COEF_W-1:0] r_g1;
    logic [nmb_pkg::SUM_W-1:0]  p1_ext;
    logic [nmb_pkg::SUM_W-1:0]  s1_sum;

    // First remainder pipeline: a1*b1 and the odd sum.
    logic [nmb_pkg::SUM_W-1:0]  r_vm  [nmb_pkg::RED_STEPS];
    logic [nmb_pkg::SUM_W-1:0]  r_vc  [nmb_pkg::RED_STEPS];
    logic [nmb_pkg::COEF_W-1:0] r_rm  [nmb_pkg::RED_STEPS];
    logic [nmb_pkg::COEF_W-1:0] r_rc  [nmb_pkg::RED_STEPS];
    logic [nmb_pkg::PROD_W-1:0] r_p0s [nmb_pkg::RED_STEPS];
    logic [nmb_pkg::COEF_W-1:0] r_gs  [nmb_pkg::RED_STEPS];

    // Gamma product and second remainder pipeline.
    logic [nmb_pkg::PROD_W-1:0] mg;
    logic [nmb_pkg::SUM_W-1:0]  r_x;
    logic [nmb_pkg::COEF_W-1:0] r_c1x;
    logic [nmb_pkg::SUM_W-1:0]  r_xv  [nmb_pkg::RED_STEPS];
    logic [nmb_pkg::COEF_W-1:0] r_xr  [nmb_pkg::RED_STEPS];
    logic [nmb_pkg::COEF_W-1:0] r_c1s [nmb_pkg::RED_STEPS];

    // Accumulator store and the reduction of what it returns.
    logic [nmb_pkg::ENTRY_W-1:0]   r_mem [nmb_pkg::DEPTH];
    logic [nmb_pkg::ENTRY_W-1:0]   r_rd;
    logic [nmb_pkg::ENTRY_W-1:0]   r_wd  [nmb_pkg::ACC_STEPS];
    logic [nmb_pkg::COEF_W-1:0]    r_wr0 [nmb_pkg::ACC_STEPS];
    logic [nmb_pkg::COEF_W-1:0]    r_wr1 [nmb_pkg::ACC_STEPS];
    logic [nmb_pkg::ACC_PAD_W-1:0] rd0_ext, rd1_ext;

    // Accumulate step and forwarding window.
    logic                   r_fw_v [nmb_pkg::FWD_DEPTH];
    nmb_pkg::t_fwd          r_fw   [nmb_pkg::FWD_DEPTH];
    logic                   fw_hit;
    logic [nmb_pkg::COEF_W-1:0] fw_e0, fw_e1;
    logic [nmb_pkg::COEF_W-1:0] w0, w1;
    logic [nmb_pkg::COEF_W:0]   sum0, sum1;
    logic [nmb_pkg::COEF_W-1:0] e0, e1;

    // Output buffer.
    logic [1:0]             r_cnt;
    logic [1:0]             n_cnt;
    nmb_pkg::t_res          r_buf [2];
    nmb_pkg::t_res          res_new;
    logic                   push;
    logic                   pop;

    // The pipeline moves as a whole while the output buffer has room.
    assign en         = (r_cnt != 2'd2);
    assign o_in_stall = !en;
    assign in_take    = i_in_valid && en;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= nmb_pkg::MOD_RESET;
            r_rank <= nmb_pkg::RANK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nmb_pkg::CFG_MODULUS: r_q    <= i_cfg_data;
                nmb_pkg::CFG_RANK:    r_rank <= i_cfg_data[nmb_pkg::RANKR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective rank, range check and entry address of the new request.
    always_comb begin
        if (r_rank == '0) begin
            k_eff = nmb_pkg::RANK_W'(1);
        end else if (int'(r_rank) > nmb_pkg::MAX_RANK) begin
            k_eff = nmb_pkg::RANK_W'(nmb_pkg::MAX_RANK);
        end else begin
            k_eff = nmb_pkg::RANK_W'(r_rank);
        end
        in_ok        = (int'(i_row) < int'(k_eff)) && (int'(i_col) < int'(k_eff));
        n_meta.first = (i_col == '0);
        n_meta.last  = (int'(i_col) == int'(k_eff) - 1);
        n_meta.row   = i_row;
        n_meta.pair  = nmb_pkg::PAIR_W'(int'(i_pair_index) % nmb_pkg::PAIRS);
        n_meta.addr  = nmb_pkg::ADDR_W'(int'(i_row) * nmb_pkg::PAIRS
                                        + int'(i_pair_index) % nmb_pkg::PAIRS);
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < nmb_pkg::N_ST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= in_take && in_ok;
            for (int k = 1; k < nmb_pkg::N_ST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Control payload shift line.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= n_meta;
            for (int k = 1; k < nmb_pkg::N_ST; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // Operand capture and the four partial products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= i_a_even;
            r_a1 <= i_a_odd;
            r_b0 <= i_s_even;
            r_b1 <= i_s_odd;
            r_g  <= i_twiddle;
            r_p0 <= nmb_pkg::PROD_W'(r_a0) * nmb_pkg::PROD_W'(r_b0);
            r_p1 <= nmb_pkg::PROD_W'(r_a1) * nmb_pkg::PROD_W'(r_b1);
            r_p2 <= nmb_pkg::PROD_W'(r_a0) * nmb_pkg::PROD_W'(r_b1);
            r_p3 <= nmb_pkg::PROD_W'(r_a1) * nmb_pkg::PROD_W'(r_b0);
            r_g1 <= r_g;
        end
    end

    assign p1_ext = nmb_pkg::SUM_W'(r_p1);
    assign s1_sum = nmb_pkg::SUM_W'(r_p2) + nmb_pkg::SUM_W'(r_p3);

    // Reduce a1*b1 and a0*b1 + a1*b0 mod q, one nibble per stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vm[0]  <= p1_ext;
            r_vc[0]  <= s1_sum;
            r_rm[0]  <= nmb_pkg::rem_chunk('0,
                            p1_ext[nmb_pkg::SUM_W-1 -: nmb_pkg::STEP_BITS], r_q);
            r_rc[0]  <= nmb_pkg::rem_chunk('0,
                            s1_sum[nmb_pkg::SUM_W-1 -: nmb_pkg::STEP_BITS], r_q);
            r_p0s[0] <= r_p0;
            r_gs[0]  <= r_g1;
            for (int k = 1; k < nmb_pkg::RED_STEPS; k++) begin
                r_vm[k]  <= r_vm[k-1];
                r_vc[k]  <= r_vc[k-1];
                r_rm[k]  <= nmb_pkg::rem_chunk(r_rm[k-1],
                    r_vm[k-1][nmb_pkg::SUM_W-1-nmb_pkg::STEP_BITS*k -: nmb_pkg::STEP_BITS],
                    r_q);
                r_rc[k]  <= nmb_pkg::rem_chunk(r_rc[k-1],
                    r_vc[k-1][nmb_pkg::SUM_W-1-nmb_pkg::STEP_BITS*k -: nmb_pkg::STEP_BITS],
                    r_q);
                r_p0s[k] <= r_p0s[k-1];
                r_gs[k]  <= r_gs[k-1];
            end
        end
    end

    // Even part before its reduction: (a1*b1 mod q) * gamma + a0*b0.
    assign mg = nmb_pkg::PROD_W'(r_rm[nmb_pkg::RED_STEPS-1])
              * nmb_pkg::PROD_W'(r_gs[nmb_pkg::RED_STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x   <= nmb_pkg::SUM_W'(mg) + nmb_pkg::SUM_W'(r_p0s[nmb_pkg::RED_STEPS-1]);
            r_c1x <= r_rc[nmb_pkg::RED_STEPS-1];
        end
    end

    // Reduce the even part mod q.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xv[0]  <= r_x;
            r_xr[0]  <= nmb_pkg::rem_chunk('0,
                            r_x[nmb_pkg::SUM_W-1 -: nmb_pkg::STEP_BITS], r_q);
            r_c1s[0] <= r_c1x;
            for (int k = 1; k < nmb_pkg::RED_STEPS; k++) begin
                r_xv[k]  <= r_xv[k-1];
                r_xr[k]  <= nmb_pkg::rem_chunk(r_xr[k-1],
                    r_xv[k-1][nmb_pkg::SUM_W-1-nmb_pkg::STEP_BITS*k -: nmb_pkg::STEP_BITS],
                    r_q);
                r_c1s[k] <= r_c1s[k-1];
            end
        end
    end

    // Stored fields may come from an earlier modulus, so reduce them again.
    assign rd0_ext = nmb_pkg::ACC_PAD_W'(r_rd[nmb_pkg::FIELD_W-1:0]);
    assign rd1_ext = nmb_pkg::ACC_PAD_W'(r_rd[nmb_pkg::ENTRY_W-1:nmb_pkg::FIELD_W]);

    // Below the top nibble every chunk lies inside the stored field.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wd[0]  <= r_rd;
            r_wr0[0] <= nmb_pkg::rem_chunk('0,
                            rd0_ext[nmb_pkg::ACC_PAD_W-1 -: nmb_pkg::STEP_BITS], r_q);
            r_wr1[0] <= nmb_pkg::rem_chunk('0,
                            rd1_ext[nmb_pkg::ACC_PAD_W-1 -: nmb_pkg::STEP_BITS], r_q);
            for (int k = 1; k < nmb_pkg::ACC_STEPS; k++) begin
                r_wd[k]  <= r_wd[k-1];
                r_wr0[k] <= nmb_pkg::rem_chunk(r_wr0[k-1],
                    r_wd[k-1][nmb_pkg::ACC_PAD_W - 1
                              - nmb_pkg::STEP_BITS*k -: nmb_pkg::STEP_BITS],
                    r_q);
                r_wr1[k] <= nmb_pkg::rem_chunk(r_wr1[k-1],
                    r_wd[k-1][nmb_pkg::FIELD_W + nmb_pkg::ACC_PAD_W - 1
                              - nmb_pkg::STEP_BITS*k -: nmb_pkg::STEP_BITS],
                    r_q);
            end
        end
    end

    // Accumulate: the newest in-flight sum for this entry wins over the store.
    always_comb begin
        fw_hit = 1'b0;
        fw_e0  = '0;
        fw_e1  = '0;
        for (int j = nmb_pkg::FWD_DEPTH - 1; j >= 0; j--) begin
            if (r_fw_v[j] && (r_fw[j].addr == r_meta[nmb_pkg::ST_ACC].addr)) begin
                fw_hit = 1'b1;
                fw_e0  = r_fw[j].e0;
                fw_e1  = r_fw[j].e1;
            end
        end
        w0 = fw_hit ? fw_e0 : r_wr0[nmb_pkg::ACC_STEPS-1];
        w1 = fw_hit ? fw_e1 : r_wr1[nmb_pkg::ACC_STEPS-1];
        if (r_meta[nmb_pkg::ST_ACC].first) begin
            w0 = '0;
            w1 = '0;
        end
        sum0 = {1'b0, w0} + {1'b0, r_xr[nmb_pkg::RED_STEPS-1]};
        sum1 = {1'b0, w1} + {1'b0, r_c1s[nmb_pkg::RED_STEPS-1]};
        if (sum0 >= {1'b0, r_q}) begin
            sum0 = sum0 - {1'b0, r_q};
        end
        if (sum1 >= {1'b0, r_q}) begin
            sum1 = sum1 - {1'b0, r_q};
        end
        e0 = sum0[nmb_pkg::COEF_W-1:0];
        e1 = sum1[nmb_pkg::COEF_W-1:0];
        // A modulus below two reduces everything to zero.
        if (r_q < nmb_pkg::MOD_MIN) begin
            e0 = '0;
            e1 = '0;
        end
    end

    // Accumulator store: registered read ahead of the reduction, write at
    // the accumulate step.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd <= r_mem[r_meta[nmb_pkg::ST_RD].addr];
            if (r_vld[nmb_pkg::ST_ACC]) begin
                r_mem[r_meta[nmb_pkg::ST_ACC].addr] <=
                    {nmb_pkg::FIELD_W'(e1), nmb_pkg::FIELD_W'(e0)};
            end
        end
    end

    // Forwarding window valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < nmb_pkg::FWD_DEPTH; j++) begin
                r_fw_v[j] <= 1'b0;
            end
        end else if (en) begin
            r_fw_v[0] <= r_vld[nmb_pkg::ST_ACC];
            for (int j = 1; j < nmb_pkg::FWD_DEPTH; j++) begin
                r_fw_v[j] <= r_fw_v[j-1];
            end
        end
    end

    // Forwarding window payload; its first slot also feeds the output.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fw[0].addr <= r_meta[nmb_pkg::ST_ACC].addr;
            r_fw[0].e0   <= e0;
            r_fw[0].e1   <= e1;
            for (int j = 1; j < nmb_pkg::FWD_DEPTH; j++) begin
                r_fw[j] <= r_fw[j-1];
            end
        end
    end

    // Output buffer: two entries, head in slot 0.
    assign res_new.row  = r_meta[nmb_pkg::ST_OUT].row;
    assign res_new.pair = r_meta[nmb_pkg::ST_OUT].pair;
    assign res_new.t0   = r_fw[0].e0;
    assign res_new.t1   = r_fw[0].e1;
    assign push = en && r_vld[nmb_pkg::ST_OUT] && r_meta[nmb_pkg::ST_OUT].last;
    assign pop  = (r_cnt != 2'd0) && !i_out_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && ((r_cnt == 2'd0) || pop)) begin
            r_buf[0] <= res_new;
        end else if (pop) begin
            r_buf[0] <= r_buf[1];
        end
        if (push && !pop && (r_cnt == 2'd1)) begin
            r_buf[1] <= res_new;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_row   = r_buf[0].row;
    assign o_out_pair  = r_buf[0].pair;
    assign o_t_even    = r_buf[0].t0;
    assign o_t_odd     = r_buf[0].t1;

endmodule

`default_nettype wire
